// File: sv/assert_macros.svh
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent property, checked on the rising edge, off while reset is low.
`define STT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("timer table assertion failed");
// Condition that must never be true.
`define STT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `STT_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define STT_ASSERT(lbl, clk, rst_n, prop)
`define STT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: sv/stt_pkg.sv
// Package: types and constants of the software timer table.
package stt_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 16;
  localparam int unsigned SLOT_FIELD_W  = 4;
  localparam int unsigned DELAY_W       = 8;
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned ENTRY_W       = DELAY_W + TAG_W;
  localparam int unsigned IN_TDATA_W    = 48;
  localparam int unsigned OUT_TDATA_W   = 40;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FLUSH
  } sweep_state_e;

  typedef struct packed {
    logic [1:0]              op;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [DELAY_W-1:0]      delay;
    logic [TAG_W-1:0]        tag;
  } cmd_t;

  typedef struct packed {
    logic                    valid;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [TAG_W-1:0]        tag;
    logic                    last;
  } expiry_t;

endpackage

// File: sv/stt_mem.sv
// Slot memory: count and tag per slot, one write port, one registered read port.
module stt_mem #(
  parameter int unsigned DEPTH = stt_pkg::NUM_SLOTS_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [stt_pkg::ENTRY_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [stt_pkg::ENTRY_W-1:0] rdata_o
);

  logic [stt_pkg::ENTRY_W-1:0] mem_q [DEPTH];
  logic [stt_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/stt_sweep.sv
// Sweep controller: command decode, armed bits, read-modify-write walk, expiry hold.
`include "assert_macros.svh"
module stt_sweep #(
  parameter int unsigned NUM_SLOTS = stt_pkg::NUM_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  stt_pkg::cmd_t    cmd_i,
  input  logic             out_free_i,
  output stt_pkg::expiry_t push_o
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned WideW = SlotW + stt_pkg::SLOT_FIELD_W;

  stt_pkg::sweep_state_e state_q, state_d;

  logic [NUM_SLOTS-1:0] armed_q, armed_d;
  logic [CntW-1:0]      rd_idx_q, rd_idx_d;
  logic                 s1_vld_q, s1_vld_d;
  logic [SlotW-1:0]     s1_idx_q, s1_idx_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [stt_pkg::SLOT_FIELD_W-1:0] pend_slot_q, pend_slot_d;
  logic [stt_pkg::TAG_W-1:0]        pend_tag_q, pend_tag_d;

  logic                  accept, in_range, arm_ok, cancel_ok, tick_go;
  logic [WideW-1:0]      in_idx_wide, s1_idx_wide;
  logic [SlotW-1:0]      in_idx;
  logic                  s1_armed, hit, stall, sweep_done;
  logic [stt_pkg::DELAY_W-1:0] rem_dec;
  logic [stt_pkg::TAG_W-1:0]   rd_tag;
  logic [stt_pkg::ENTRY_W-1:0] rdata, wdata;
  logic                  we, re;
  logic [SlotW-1:0]      waddr;

  // decode
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign in_idx_wide = {{SlotW{1'b0}}, cmd_i.slot};
  assign in_range    = in_idx_wide < WideW'(NUM_SLOTS);
  assign in_idx      = in_idx_wide[SlotW-1:0];

  always_comb begin
    arm_ok    = 1'b0;
    cancel_ok = 1'b0;
    tick_go   = 1'b0;
    unique case (cmd_i.op)
      stt_pkg::OP_ARM:    arm_ok    = accept && in_range;
      stt_pkg::OP_CANCEL: cancel_ok = accept && in_range;
      stt_pkg::OP_TICK:   tick_go   = accept;
      default: ;
    endcase
  end

  // stage 1: read data of the slot fetched by the last read
  assign rd_tag      = rdata[stt_pkg::ENTRY_W-1:stt_pkg::DELAY_W];
  assign rem_dec     = rdata[stt_pkg::DELAY_W-1:0] - stt_pkg::DELAY_W'(1);
  assign s1_armed    = armed_q[s1_idx_q];
  assign hit         = s1_vld_q && s1_armed && (rem_dec == '0);
  assign stall       = hit && pend_vld_q && !out_free_i;
  assign s1_idx_wide = {{stt_pkg::SLOT_FIELD_W{1'b0}}, s1_idx_q};
  assign sweep_done  = (rd_idx_q == CntW'(NUM_SLOTS)) && !s1_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stt_pkg::ST_IDLE:  if (tick_go) state_d = stt_pkg::ST_SWEEP;
      stt_pkg::ST_SWEEP: if (sweep_done) state_d = stt_pkg::ST_FLUSH;
      stt_pkg::ST_FLUSH: if (!pend_vld_q || out_free_i) state_d = stt_pkg::ST_IDLE;
      default:           state_d = stt_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cmd_ready_o = (state_q == stt_pkg::ST_IDLE);
    re          = 1'b0;
    we          = 1'b0;
    waddr       = in_idx;
    wdata       = {cmd_i.tag, cmd_i.delay};
    push_o      = '0;
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        we = arm_ok;
      end
      stt_pkg::ST_SWEEP: begin
        re    = (rd_idx_q < CntW'(NUM_SLOTS)) && !stall;
        we    = s1_vld_q && s1_armed && !stall;
        waddr = s1_idx_q;
        wdata = {rd_tag, rem_dec};
        // a new expiry pushes the held one out, not last
        push_o.valid = hit && pend_vld_q && !stall;
        push_o.slot  = pend_slot_q;
        push_o.tag   = pend_tag_q;
        push_o.last  = 1'b0;
      end
      stt_pkg::ST_FLUSH: begin
        push_o.valid = pend_vld_q && out_free_i;
        push_o.slot  = pend_slot_q;
        push_o.tag   = pend_tag_q;
        push_o.last  = 1'b1;
      end
      default: ;
    endcase
  end

  // register next values
  always_comb begin
    armed_d     = armed_q;
    rd_idx_d    = rd_idx_q;
    s1_vld_d    = s1_vld_q;
    s1_idx_d    = s1_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    pend_tag_d  = pend_tag_q;
    if (arm_ok) armed_d[in_idx] = 1'b1;
    if (cancel_ok) armed_d[in_idx] = 1'b0;
    if (tick_go) rd_idx_d = '0;
    if (re) begin
      rd_idx_d = rd_idx_q + CntW'(1);
      s1_idx_d = rd_idx_q[SlotW-1:0];
    end
    if (!stall) s1_vld_d = re;
    if (hit && !stall) begin
      armed_d[s1_idx_q] = 1'b0;
      pend_vld_d        = 1'b1;
      pend_slot_d       = s1_idx_wide[stt_pkg::SLOT_FIELD_W-1:0];
      pend_tag_d        = rd_tag;
    end
    if (state_q == stt_pkg::ST_FLUSH && out_free_i) pend_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= stt_pkg::ST_IDLE;
      armed_q    <= '0;
      rd_idx_q   <= '0;
      s1_vld_q   <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      armed_q    <= armed_d;
      rd_idx_q   <= rd_idx_d;
      s1_vld_q   <= s1_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q    <= s1_idx_d;
    pend_slot_q <= pend_slot_d;
    pend_tag_q  <= pend_tag_d;
  end

  stt_mem #(
    .DEPTH(NUM_SLOTS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(rd_idx_q[SlotW-1:0]),
    .rdata_o(rdata)
  );

  `STT_ASSERT(a_idle_clean, clk_i, rst_ni, (state_q == stt_pkg::ST_IDLE) |-> (!pend_vld_q && !s1_vld_q))
  `STT_ASSERT(a_stall_holds, clk_i, rst_ni, stall |=> ($stable(s1_idx_q) && s1_vld_q))
  `STT_ASSERT(a_push_has_room, clk_i, rst_ni, push_o.valid |-> out_free_i)
  `STT_ASSERT_NEVER(a_idx_range, clk_i, rst_ni, rd_idx_q > CntW'(NUM_SLOTS))

endmodule

// File: sv/software_timer_table.sv
// Top level of the one-shot software timer table.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  op, slot, delay_ticks, msg_tag
//  m_axis   out  m_axis_tvalid / m_axis_tready  expired_slot, expired_tag, tlast
//
// Arm and cancel are taken in the idle state and leave the input open. A tick walks
// the slot memory one slot per cycle while the output does not stall it, through
// the single read port of the memory, and keeps the input closed until its flush is done.
// Output back-pressure adds stall cycles only once two expiries are held.
// Reset clears all armed marks at once; counts and tags need no clearing.
// New items are taken once the previous tick has its last result, if any, in the output register.
module software_timer_table #(
  parameter int unsigned NUM_SLOTS = stt_pkg::NUM_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // op[1:0], slot[5:2], delay_ticks[13:6], msg_tag[45:14], zero fill
  input  logic [stt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // expired_slot[3:0], expired_tag[35:4], zero fill
  output logic [stt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  stt_pkg::cmd_t    cmd;
  stt_pkg::expiry_t push;
  logic             out_free;

  logic                                 out_vld_q, out_vld_d;
  logic [stt_pkg::SLOT_FIELD_W-1:0]     out_slot_q;
  logic [stt_pkg::TAG_W-1:0]            out_tag_q;
  logic                                 out_last_q;

  // unpack the input transfer
  assign cmd.op    = s_axis_tdata[1:0];
  assign cmd.slot  = s_axis_tdata[5:2];
  assign cmd.delay = s_axis_tdata[13:6];
  assign cmd.tag   = s_axis_tdata[45:14];

  stt_sweep #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(s_axis_tvalid),
    .cmd_ready_o(s_axis_tready),
    .cmd_i      (cmd),
    .out_free_i (out_free),
    .push_o     (push)
  );

  // output register: refilled in the same cycle the current result leaves
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (push.valid) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid) begin
      out_slot_q <= push.slot;
      out_tag_q  <= push.tag;
      out_last_q <= push.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_tag_q, out_slot_q};
  assign m_axis_tlast  = out_last_q;

endmodule
